>>> hw/rtl/fpt_pkg.sv
// Shared types, constants and helpers for the four-level page table update block.
package fpt_pkg;

  localparam int POOL_PAGES_DEF = 64;
  localparam int IDX_W          = 9;
  localparam int ENTRIES        = 512;
  localparam int NFP_W          = 13;
  localparam int ENT_W          = 64;
  localparam int PA_W           = 52;
  localparam int CFG_IDX_W      = 2;

  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_UNMAP = 2'd1;
  localparam logic [1:0] OP_CACHE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_OUTSIDE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_USER_END  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd2;

  localparam logic [63:0] USER_END_RST = 64'h0000_8000_0000_0000;

  localparam logic [1:0] CT_WB = 2'd0;
  localparam logic [1:0] CT_WT = 2'd1;
  localparam logic [1:0] CT_UC = 2'd2;
  localparam logic [1:0] CT_WC = 2'd3;

  localparam logic [ENT_W-1:0] F_PWT      = 64'h8;
  localparam logic [ENT_W-1:0] F_PCD      = 64'h10;
  localparam logic [ENT_W-1:0] F_PAT      = 64'h80;
  localparam logic [ENT_W-1:0] F_GLOBAL   = 64'h100;
  localparam logic [ENT_W-1:0] CACHE_MASK = F_PWT | F_PCD | F_PAT;

  typedef struct packed {
    logic [63:0]     user_space_end;
    logic            global_pages_enable;
    logic [PA_W-1:0] table_pool_base;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [63:0]     virt_addr;
    logic [PA_W-1:0] phys_addr;
    logic            write_enable;
    logic [1:0]      cache_type;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ENT_W-1:0] leaf_entry;
    logic             tlb_invalidate;
  } res_t;

  function automatic logic [ENT_W-1:0] cache_bits(input logic [1:0] ct);
    logic [ENT_W-1:0] b;
    case (ct)
      CT_WT:   b = F_PWT;
      CT_UC:   b = F_PCD;
      CT_WC:   b = F_PAT;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/fpt_if.sv
// Valid/ready channel interfaces for command items and result items.
interface fpt_in_if;
  import fpt_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      opcode;
  logic [63:0]     virt_addr;
  logic [PA_W-1:0] phys_addr;
  logic            write_enable;
  logic [1:0]      cache_type;

  modport source (output valid, opcode, virt_addr, phys_addr, write_enable, cache_type,
                  input ready);
  modport sink (input valid, opcode, virt_addr, phys_addr, write_enable, cache_type,
                output ready);
endinterface

interface fpt_out_if;
  import fpt_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [ENT_W-1:0] leaf_entry;
  logic             tlb_invalidate;

  modport source (output valid, status, leaf_entry, tlb_invalidate, input ready);
  modport sink (input valid, status, leaf_entry, tlb_invalidate, output ready);
endinterface

>>> hw/rtl/four_level_page_table_update_top.sv
// Top level of the four-level page table update block.
//
//   channel  direction  handshake        payload
//   in_if    in         valid / ready    opcode, virt_addr, phys_addr, write_enable, cache_type
//   out_if   out        valid / ready    status, leaf_entry, tlb_invalidate
//   cfg_*    in         cfg_we only      cfg_index, cfg_wdata
//
// An item is walked one level at a time, a table read and then its evaluation per level, from
// acceptance to its result in the output register; a missing table page on a map is cleared
// entry by entry and linked in, and the walk is bound by the table memory's single read port and
// single write port. After reset the table memory is cleared, with in_if.ready low.
// A result waits in the output register while the next item is accepted and walked.
module four_level_page_table_update_top #(
  parameter int POOL_PAGES = fpt_pkg::POOL_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fpt_in_if.sink                        in_if,
  fpt_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [fpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata
);
  import fpt_pkg::*;

  localparam int PW    = $clog2(POOL_PAGES);
  localparam int AW    = PW + IDX_W;
  localparam int DEPTH = POOL_PAGES * ENTRIES;

  cfg_t             cfg_r;
  item_t            in_item;
  res_t             res, out_res_r;
  logic             out_valid_r;
  logic             res_valid, res_ready;
  logic             wr_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [ENT_W-1:0] wr_data, rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.user_space_end      <= USER_END_RST;
      cfg_r.global_pages_enable <= 1'b0;
      cfg_r.table_pool_base     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USER_END:  cfg_r.user_space_end      <= cfg_wdata;
        CFG_GLOBAL_EN: cfg_r.global_pages_enable <= cfg_wdata[0];
        CFG_POOL_BASE: cfg_r.table_pool_base     <= {cfg_wdata[PA_W-1:12], 12'h000};
        default: ;
      endcase
    end
  end

  assign in_item = '{opcode: in_if.opcode, virt_addr: in_if.virt_addr,
                     phys_addr: in_if.phys_addr, write_enable: in_if.write_enable,
                     cache_type: in_if.cache_type};

  assign res_ready = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_res_r.status;
  assign out_if.leaf_entry     = out_res_r.leaf_entry;
  assign out_if.tlb_invalidate = out_res_r.tlb_invalidate;

  fpt_walk #(
    .POOL_PAGES (POOL_PAGES),
    .PW         (PW),
    .AW         (AW)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  fpt_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

>>> hw/rtl/fpt_mem.sv
// Table store: one write port and one registered read port.
module fpt_mem #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [fpt_pkg::ENT_W-1:0] wr_data,
  input  logic [AW-1:0]            rd_addr,
  output logic [fpt_pkg::ENT_W-1:0] rd_data
);
  import fpt_pkg::*;

  logic [ENT_W-1:0] mem_r [DEPTH];
  logic [ENT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/fpt_walk.sv
// Walk sequencer: reads, modifies and writes table entries one level at a time.
module fpt_walk #(
  parameter int POOL_PAGES = fpt_pkg::POOL_PAGES_DEF,
  parameter int PW         = $clog2(POOL_PAGES),
  parameter int AW         = PW + fpt_pkg::IDX_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fpt_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  fpt_pkg::item_t            in_item,
  output logic                      res_valid,
  input  logic                      res_ready,
  output fpt_pkg::res_t             res,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [fpt_pkg::ENT_W-1:0] wr_data,
  output logic [AW-1:0]             rd_addr,
  input  logic [fpt_pkg::ENT_W-1:0] rd_data
);
  import fpt_pkg::*;

  localparam int DEPTH = POOL_PAGES * ENTRIES;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_SWP  = 3'd4;
  localparam logic [2:0] S_ALC  = 3'd5;
  localparam logic [2:0] S_LEAF = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0] swp_cnt_r, swp_cnt_nxt;
  logic [NFP_W-1:0] nfp_r, nfp_nxt;
  item_t            item_r, item_nxt;
  logic [2:0]       flags_r, flags_nxt;
  logic             glob_r, glob_nxt;
  logic [1:0]       lvl_r, lvl_nxt;
  logic [PW-1:0]    page_r, page_nxt;
  logic [AW-1:0]    slot_addr_r, slot_addr_nxt;
  res_t             res_r, res_nxt;

  logic [IDX_W-1:0] lvl_idx;
  logic [ENT_W-1:0] flags64, alloc_val, cand, leaf_map, leaf_cache, leaf_new;
  logic [50:0]      addr_pg, base_pg, off;
  logic             outside;
  logic             is_map;

  always_comb begin
    case (lvl_r)
      2'd3:    lvl_idx = item_r.virt_addr[47:39];
      2'd2:    lvl_idx = item_r.virt_addr[38:30];
      2'd1:    lvl_idx = item_r.virt_addr[29:21];
      default: lvl_idx = item_r.virt_addr[20:12];
    endcase
  end

  assign rd_addr  = {page_r, lvl_idx};
  assign is_map   = (item_r.opcode == OP_MAP);
  assign flags64  = {{(ENT_W-3){1'b0}}, flags_r};

  // A fresh table page points at base + page * 4096, with the walk flags added.
  assign alloc_val = (ENT_W'(cfg.table_pool_base)
                      + {{(ENT_W-NFP_W-12){1'b0}}, nfp_r, 12'h000}) | flags64;
  assign cand = (state_r == S_ALC) ? alloc_val :
                (is_map ? (rd_data | flags64) : rd_data);

  // Turn the entry's address into a pool page number, flagging misses.
  assign addr_pg = cand[62:12];
  assign base_pg = 51'(cfg.table_pool_base[PA_W-1:12]);
  assign off     = addr_pg - base_pg;
  assign outside = (addr_pg < base_pg) || (off >= 51'(POOL_PAGES));

  assign leaf_map   = flags64 | ENT_W'(item_r.phys_addr) | (glob_r ? F_GLOBAL : '0);
  assign leaf_cache = (rd_data & ~CACHE_MASK) | cache_bits(item_r.cache_type);
  assign leaf_new   = (item_r.opcode == OP_UNMAP) ? '0 : leaf_cache;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    swp_cnt_nxt   = swp_cnt_r;
    nfp_nxt       = nfp_r;
    item_nxt      = item_r;
    flags_nxt     = flags_r;
    glob_nxt      = glob_r;
    lvl_nxt       = lvl_r;
    page_nxt      = page_r;
    slot_addr_nxt = slot_addr_r;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    wr_addr       = slot_addr_r;
    wr_data       = cand;

    case (state_r)
      S_INIT: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          flags_nxt = {in_item.virt_addr < cfg.user_space_end, in_item.write_enable, 1'b1};
          glob_nxt  = !(in_item.virt_addr < cfg.user_space_end) && cfg.global_pages_enable;
          lvl_nxt   = 2'd3;
          page_nxt  = '0;
          if (in_item.opcode == OP_MAP || in_item.opcode == OP_UNMAP ||
              in_item.opcode == OP_CACHE) begin
            state_nxt = S_RD;
          end else begin
            res_nxt   = '{status: ST_OK, leaf_entry: '0, tlb_invalidate: 1'b0};
            state_nxt = S_DONE;
          end
        end
      end
      S_RD: begin
        slot_addr_nxt = rd_addr;
        state_nxt     = S_EV;
      end
      S_EV: begin
        if (lvl_r != 2'd0) begin
          if (!rd_data[0] && is_map) begin
            if (nfp_r >= NFP_W'(POOL_PAGES)) begin
              res_nxt   = '{status: ST_EXHAUSTED, leaf_entry: '0, tlb_invalidate: 1'b0};
              state_nxt = S_DONE;
            end else begin
              swp_cnt_nxt = '0;
              state_nxt   = S_SWP;
            end
          end else if (!rd_data[0]) begin
            res_nxt   = '{status: ST_NOT_FOUND, leaf_entry: '0, tlb_invalidate: 1'b0};
            state_nxt = S_DONE;
          end else begin
            wr_en = is_map;
            if (outside) begin
              res_nxt   = '{status: ST_OUTSIDE, leaf_entry: '0, tlb_invalidate: 1'b0};
              state_nxt = S_DONE;
            end else begin
              page_nxt  = off[PW-1:0];
              lvl_nxt   = lvl_r - 2'd1;
              state_nxt = (lvl_r == 2'd1 && is_map) ? S_LEAF : S_RD;
            end
          end
        end else begin
          if (!rd_data[0]) begin
            res_nxt   = '{status: ST_NOT_FOUND, leaf_entry: '0, tlb_invalidate: 1'b0};
          end else begin
            wr_en   = 1'b1;
            wr_data = leaf_new;
            res_nxt = '{status: ST_OK, leaf_entry: leaf_new, tlb_invalidate: 1'b1};
          end
          state_nxt = S_DONE;
        end
      end
      S_SWP: begin
        // Clear the page being handed out, one entry per cycle.
        wr_en       = 1'b1;
        wr_addr     = {nfp_r[PW-1:0], swp_cnt_r};
        wr_data     = '0;
        swp_cnt_nxt = swp_cnt_r + 1'b1;
        if (swp_cnt_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = S_ALC;
        end
      end
      S_ALC: begin
        wr_en   = 1'b1;
        nfp_nxt = nfp_r + 1'b1;
        if (outside) begin
          res_nxt   = '{status: ST_OUTSIDE, leaf_entry: '0, tlb_invalidate: 1'b0};
          state_nxt = S_DONE;
        end else begin
          page_nxt  = off[PW-1:0];
          lvl_nxt   = lvl_r - 2'd1;
          state_nxt = (lvl_r == 2'd1) ? S_LEAF : S_RD;
        end
      end
      S_LEAF: begin
        wr_en     = 1'b1;
        wr_addr   = rd_addr;
        wr_data   = leaf_map;
        res_nxt   = '{status: ST_OK, leaf_entry: leaf_map, tlb_invalidate: 1'b0};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      clr_cnt_r <= '0;
      nfp_r     <= NFP_W'(1);
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      nfp_r     <= nfp_nxt;
    end
    swp_cnt_r   <= swp_cnt_nxt;
    item_r      <= item_nxt;
    flags_r     <= flags_nxt;
    glob_r      <= glob_nxt;
    lvl_r       <= lvl_nxt;
    page_r      <= page_nxt;
    slot_addr_r <= slot_addr_nxt;
    res_r       <= res_nxt;
  end

endmodule

>>> hw/rtl/fpt_checker.sv
// Port-level checks for the page table update block, bound to its top level.
module fpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [63:0] out_leaf,
  input logic        out_tlb
);
  import fpt_pkg::*;

  // Items are walked one at a time, so taking an item closes the input for a while.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an item was accepted");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_leaf == 64'd0 && !out_tlb)
    else $error("failed result carries a leaf entry or an invalidate");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_leaf)
                                && $stable(out_tlb))
    else $error("stalled result changed");

endmodule

bind four_level_page_table_update_top fpt_checker u_fpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_status (out_if.status),
  .out_leaf   (out_if.leaf_entry),
  .out_tlb    (out_if.tlb_invalidate)
);
